// ===== rtl/rrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrpt_pkg
// Shared types, widths and register codes of the rotated region point test.
// ----------------------------------------------------------------------------
`default_nettype none

package rrpt_pkg;

  // Field widths of the ports.
  localparam int PT_W    = 12;  // integer pixel coordinate
  localparam int FRAC_W  = 4;   // fraction bits of a coordinate
  localparam int TRIG_F  = 14;  // fraction bits of cosine and sine
  localparam int CFG_W   = 16;  // widest configuration register
  localparam int CIDX_W  = 3;   // register index

  // Derived datapath widths.
  localparam int CRD_W   = PT_W + FRAC_W;      // scaled coordinate
  localparam int D_W     = CRD_W + 1;          // signed offset from center
  localparam int P_W     = D_W + CFG_W;        // offset times trig value
  localparam int S_W     = P_W + 1;            // rotated coordinate
  localparam int M_W     = CRD_W + CFG_W;      // magnitude of rotated coordinate
  localparam int A_W     = M_W + CFG_W;        // magnitude times extent
  localparam int HALF_W  = A_W / 2;            // low partial-product slice
  localparam int AH_W    = A_W - HALF_W;       // high slice of a and b
  localparam int R_W     = 2 * CFG_W + TRIG_F; // scaled radius product
  localparam int RH_W    = R_W - HALF_W;       // high slice of r
  localparam int SQ_W    = 2 * A_W;            // square of a or b
  localparam int LHS_W   = SQ_W + 1;           // sum of two squares

  // Shape selector.
  typedef enum logic {
    SHAPE_ELLIPSE = 1'b0,
    SHAPE_RECT    = 1'b1
  } shape_t;

  // Register indexes on the configuration port.
  typedef enum logic [CIDX_W-1:0] {
    CFG_SHAPE_KIND = 3'd0,
    CFG_CENTER_X   = 3'd1,
    CFG_CENTER_Y   = 3'd2,
    CFG_COS_ANGLE  = 3'd3,
    CFG_SIN_ANGLE  = 3'd4,
    CFG_EXTENT_X   = 3'd5,
    CFG_EXTENT_Y   = 3'd6
  } cfg_idx_t;

  // Reset value of the cosine register, 1.0 in Q1.14.
  localparam logic [CFG_W-1:0] COS_RESET = CFG_W'(1 << TRIG_F);

endpackage

`default_nettype wire

// ===== rtl/rotated_region_point_test.sv =====
// ----------------------------------------------------------------------------
// rotated_region_point_test
// Tests whether a pixel lies inside a rotated ellipse or rectangle.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration is written through cfg_we / cfg_index / cfg_data while no
//   item is in flight; indexes above the last register are ignored.
//   Input channel: point_x, point_y with in_valid; the block raises in_stall
//   to hold off a transfer. Output channel: inside_res, degenerate with
//   out_valid; the receiver raises out_stall to hold a result.
// Depth and throughput:
//   Seven register stages. One item is taken every cycle when the output is
//   not stalled. The depth is set by the rotation and extent multipliers
//   and the split 48-bit squaring of the ellipse test.
// Stall behavior:
//   Each stage moves when it is empty or the stage after it moves, so a
//   stall fills bubbles first and then backs up to in_stall; no item is
//   lost or repeated.
// Reset:
//   rst clears all stage valid bits and restores the register defaults
//   (ellipse, center zero, angle zero, extents zero).
// ----------------------------------------------------------------------------
`default_nettype none

module rotated_region_point_test (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration port
  input  wire logic                        cfg_we,
  input  wire logic [rrpt_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [rrpt_pkg::CFG_W-1:0]  cfg_data,
  // Input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [rrpt_pkg::PT_W-1:0]   point_x,
  input  wire logic [rrpt_pkg::PT_W-1:0]   point_y,
  // Output channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             inside_res,
  output logic                             degenerate
);

  import rrpt_pkg::*;

  localparam int NSTG = 7;

  // Configuration registers.
  shape_t                   shape_kind;
  logic        [CFG_W-1:0]  center_x;
  logic        [CFG_W-1:0]  center_y;
  logic signed [CFG_W-1:0]  cos_angle;
  logic signed [CFG_W-1:0]  sin_angle;
  logic        [CFG_W-1:0]  extent_x;
  logic        [CFG_W-1:0]  extent_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind <= SHAPE_ELLIPSE;
      center_x   <= '0;
      center_y   <= '0;
      cos_angle  <= COS_RESET;
      sin_angle  <= '0;
      extent_x   <= '0;
      extent_y   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHAPE_KIND: shape_kind <= shape_t'(cfg_data[0]);
        CFG_CENTER_X:   center_x   <= cfg_data;
        CFG_CENTER_Y:   center_y   <= cfg_data;
        CFG_COS_ANGLE:  cos_angle  <= cfg_data;
        CFG_SIN_ANGLE:  sin_angle  <= cfg_data;
        CFG_EXTENT_X:   extent_x   <= cfg_data;
        CFG_EXTENT_Y:   extent_y   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or the next one loads.
  logic [NSTG:1]   vld;
  logic [NSTG+1:1] adv;

  always_comb begin
    adv[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: scale the point and take its offset from the center.
  logic signed [D_W-1:0] s1_dx;
  logic signed [D_W-1:0] s1_dy;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_dx <= $signed({1'b0, point_x, FRAC_W'(0)}) - $signed({1'b0, center_x});
      s1_dy <= $signed({1'b0, point_y, FRAC_W'(0)}) - $signed({1'b0, center_y});
    end
  end

  // Stage 2: the four rotation products.
  logic signed [P_W-1:0] s2_dxc;
  logic signed [P_W-1:0] s2_dys;
  logic signed [P_W-1:0] s2_dyc;
  logic signed [P_W-1:0] s2_dxs;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_dxc <= P_W'(s1_dx * cos_angle);
      s2_dys <= P_W'(s1_dy * sin_angle);
      s2_dyc <= P_W'(s1_dy * cos_angle);
      s2_dxs <= P_W'(s1_dx * sin_angle);
    end
  end

  // Stage 3: rotate by minus the angle and take magnitudes.
  logic signed [S_W-1:0] rot_x;
  logic signed [S_W-1:0] rot_y;
  logic        [S_W-1:0] neg_x;
  logic        [S_W-1:0] neg_y;
  logic        [M_W-1:0] s3_ax;
  logic        [M_W-1:0] s3_ay;

  always_comb begin
    rot_x = S_W'(s2_dxc) + S_W'(s2_dys);
    rot_y = S_W'(s2_dyc) - S_W'(s2_dxs);
    neg_x = -rot_x;
    neg_y = -rot_y;
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_ax <= rot_x[S_W-1] ? neg_x[M_W-1:0] : rot_x[M_W-1:0];
      s3_ay <= rot_y[S_W-1] ? neg_y[M_W-1:0] : rot_y[M_W-1:0];
    end
  end

  // Stage 4: scale by the extents; the rectangle test finishes here.
  logic [A_W-1:0]       s4_a;
  logic [A_W-1:0]       s4_b;
  logic [R_W-1:0]       s4_r;
  logic                 s4_rect_in;
  logic [2*CFG_W-1:0]   ext_prod;

  assign ext_prod = extent_x * extent_y;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_a       <= s3_ax * extent_y;
      s4_b       <= s3_ay * extent_x;
      s4_r       <= {ext_prod, TRIG_F'(0)};
      s4_rect_in <= ({s3_ax, 1'b0} <= (M_W+1)'({extent_x, TRIG_F'(0)})) &&
                    ({s3_ay, 1'b0} <= (M_W+1)'({extent_y, TRIG_F'(0)}));
    end
  end

  // Stage 5: partial products of the three squares.
  logic [2*AH_W-1:0]        s5_ahh, s5_bhh;
  logic [AH_W+HALF_W-1:0]   s5_ahl, s5_bhl;
  logic [2*HALF_W-1:0]      s5_all, s5_bll;
  logic [2*RH_W-1:0]        s5_rhh;
  logic [RH_W+HALF_W-1:0]   s5_rhl;
  logic [2*HALF_W-1:0]      s5_rll;
  logic                     s5_rect_in;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_ahh     <= s4_a[A_W-1:HALF_W] * s4_a[A_W-1:HALF_W];
      s5_ahl     <= s4_a[A_W-1:HALF_W] * s4_a[HALF_W-1:0];
      s5_all     <= s4_a[HALF_W-1:0]   * s4_a[HALF_W-1:0];
      s5_bhh     <= s4_b[A_W-1:HALF_W] * s4_b[A_W-1:HALF_W];
      s5_bhl     <= s4_b[A_W-1:HALF_W] * s4_b[HALF_W-1:0];
      s5_bll     <= s4_b[HALF_W-1:0]   * s4_b[HALF_W-1:0];
      s5_rhh     <= s4_r[R_W-1:HALF_W] * s4_r[R_W-1:HALF_W];
      s5_rhl     <= s4_r[R_W-1:HALF_W] * s4_r[HALF_W-1:0];
      s5_rll     <= s4_r[HALF_W-1:0]   * s4_r[HALF_W-1:0];
      s5_rect_in <= s4_rect_in;
    end
  end

  // Stage 6: assemble the squares from their partial products.
  logic [SQ_W-1:0]  s6_a2;
  logic [SQ_W-1:0]  s6_b2;
  logic [SQ_W-1:0]  s6_r2;
  logic             s6_rect_in;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_a2 <= (SQ_W'(s5_ahh) << (2*HALF_W)) + (SQ_W'(s5_ahl) << (HALF_W+1)) +
               SQ_W'(s5_all);
      s6_b2 <= (SQ_W'(s5_bhh) << (2*HALF_W)) + (SQ_W'(s5_bhl) << (HALF_W+1)) +
               SQ_W'(s5_bll);
      s6_r2 <= (SQ_W'(s5_rhh) << (2*HALF_W)) + (SQ_W'(s5_rhl) << (HALF_W+1)) +
               SQ_W'(s5_rll);
      s6_rect_in <= s5_rect_in;
    end
  end

  // Stage 7: ellipse compare and the output register.
  logic [LHS_W-1:0] lhs;
  logic             ell_degen;
  logic             ell_in;

  always_comb begin
    lhs       = LHS_W'(s6_a2) + LHS_W'(s6_b2);
    ell_degen = (extent_x == '0) || (extent_y == '0);
    ell_in    = !ell_degen && (lhs <= LHS_W'(s6_r2));
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      inside_res <= (shape_kind == SHAPE_RECT) ? s6_rect_in : ell_in;
      degenerate <= (shape_kind == SHAPE_ELLIPSE) && ell_degen;
    end
  end

  assign out_valid = vld[NSTG];

  // A degenerate ellipse never reports a point inside.
  a_degen_outside : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(degenerate && inside_res))
    else $error("degenerate result reported inside");

  // Only an ellipse can be degenerate.
  a_degen_ellipse : assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (shape_kind == SHAPE_ELLIPSE))
    else $error("degenerate flag on a rectangle");

  // A full pipeline behind a stalled output must hold off the input.
  a_full_backpressure : assert property (@(posedge clk) disable iff (rst)
    ((&vld) && out_stall) |-> in_stall)
    else $error("input taken while pipeline full and stalled");

  // An input transfer always lands in the first stage.
  a_first_stage_load : assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[1])
    else $error("accepted item missing from first stage");

endmodule

`default_nettype wire

// ===== tb/sv/rotated_region_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_region_point_checker
// Watches the register port and both channels of the rotated region point
// test. It keeps its own copy of the region registers, works out the verdict
// for each point transfer and compares it with the result transfers in order.
// ----------------------------------------------------------------------------

module rotated_region_point_checker
  import rrpt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [PT_W-1:0]     point_x,
  input  logic [PT_W-1:0]     point_y,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                inside_res,
  input  logic                degenerate,
  output int                  fail_count,
  output int                  pending
);

  // One predicted verdict per point.
  typedef struct packed {
    logic in_region;
    logic degen;
  } region_verdict_t;

  // Shadow copy of the region registers.
  shape_t                   shape_q;
  logic [CFG_W-1:0]         ctr_x;
  logic [CFG_W-1:0]         ctr_y;
  logic signed [CFG_W-1:0]  cos_q;
  logic signed [CFG_W-1:0]  sin_q;
  logic [CFG_W-1:0]         ext_x;
  logic [CFG_W-1:0]         ext_y;

  region_verdict_t verdict_queue[$];

  // Translate the point to the center, rotate by minus the angle and test it
  // against the ellipse or the rectangle. All arithmetic is exact.
  function automatic region_verdict_t classify_point(logic [PT_W-1:0] px,
                                                     logic [PT_W-1:0] py);
    longint          dx;
    longint          dy;
    longint          rot_x;
    longint          rot_y;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned wl;
    longint unsigned hl;
    logic [127:0]    a_w;
    logic [127:0]    b_w;
    logic [127:0]    r_w;
    region_verdict_t v;
    dx    = (longint'(px) << FRAC_W) - longint'(ctr_x);
    dy    = (longint'(py) << FRAC_W) - longint'(ctr_y);
    rot_x = dx * longint'(cos_q) + dy * longint'(sin_q);
    rot_y = dy * longint'(cos_q) - dx * longint'(sin_q);
    ax    = (rot_x < 0) ? -rot_x : rot_x;
    ay    = (rot_y < 0) ? -rot_y : rot_y;
    v     = '0;
    if (shape_q == SHAPE_ELLIPSE) begin
      // A zero radius makes the ellipse degenerate; it then holds no point.
      if (ext_x == '0 || ext_y == '0) begin
        v.degen = 1'b1;
      end else begin
        a_w = ax;
        a_w = a_w * ext_y;
        b_w = ay;
        b_w = b_w * ext_x;
        r_w = ext_x;
        r_w = (r_w * ext_y) << TRIG_F;
        v.in_region = ((a_w * a_w + b_w * b_w) <= r_w * r_w);
      end
    end else begin
      wl = ext_x;
      wl = wl << TRIG_F;
      hl = ext_y;
      hl = hl << TRIG_F;
      v.in_region = ((ax << 1) <= wl) && ((ay << 1) <= hl);
    end
    return v;
  endfunction

  // Track register writes, queue a verdict per point transfer and compare
  // each result transfer against the oldest queued verdict.
  always @(posedge clk) begin
    region_verdict_t want;
    if (rst) begin
      shape_q = SHAPE_ELLIPSE;
      ctr_x   = '0;
      ctr_y   = '0;
      cos_q   = COS_RESET;
      sin_q   = '0;
      ext_x   = '0;
      ext_y   = '0;
      verdict_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SHAPE_KIND: shape_q = shape_t'(cfg_data[0]);
          CFG_CENTER_X:   ctr_x = cfg_data;
          CFG_CENTER_Y:   ctr_y = cfg_data;
          CFG_COS_ANGLE:  cos_q = cfg_data;
          CFG_SIN_ANGLE:  sin_q = cfg_data;
          CFG_EXTENT_X:   ext_x = cfg_data;
          CFG_EXTENT_Y:   ext_y = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (verdict_queue.size() == 0) begin
          $display("%0t: unexpected result, actual inside=%0b degenerate=%0b",
                   $time, inside_res, degenerate);
          fail_count = fail_count + 1;
        end else begin
          want = verdict_queue.pop_front();
          if (inside_res !== want.in_region) begin
            $display("%0t: inside_res mismatch, expected %0b actual %0b",
                     $time, want.in_region, inside_res);
            fail_count = fail_count + 1;
          end
          if (degenerate !== want.degen) begin
            $display("%0t: degenerate mismatch, expected %0b actual %0b",
                     $time, want.degen, degenerate);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        verdict_queue.insert(verdict_queue.size(), classify_point(point_x, point_y));
      end
    end
    pending = verdict_queue.size();
  end

endmodule

// ===== tb/sv/rotated_region_point_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_region_point_test_tb
// Drives the rotated region point test with a directed set of regions and
// points, then with random regions and points clustered around them, under
// random gaps and stalls. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module rotated_region_point_test_tb;
  import rrpt_pkg::*;

  localparam int                CYCLE_LIMIT    = 500000;
  localparam int                RANDOM_POINTS  = 950;
  localparam int                MAX_PX         = (1 << PT_W) - 1;
  localparam logic [CIDX_W-1:0] CFG_IDX_SPARE  = 3'd7;
  localparam real               PI_VAL         = 3.14159265358979;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [PT_W-1:0]   point_x;
  logic [PT_W-1:0]   point_y;
  logic              out_valid;
  logic              out_stall;
  logic              inside_res;
  logic              degenerate;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent_count  = 0;
  bit quiet       = 1'b0;

  rotated_region_point_test u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res),
    .degenerate (degenerate)
  );

  rotated_region_point_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .inside_res (inside_res),
    .degenerate (degenerate),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle cycles before the next transfer; none during quiet stretches.
  function automatic int idle_draw();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Result side: after each result transfer, hold off for a random count.
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        hold = idle_draw();
        if (hold > 0) begin
          @(negedge clk);
          out_stall = 1'b1;
          repeat (hold) @(negedge clk);
          out_stall = 1'b0;
        end
      end
    end
  end

  // One register write; called and returning at a falling edge.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Wait until every point in flight has produced its result, then set up a
  // new region. A write to the unused index goes first and must be ignored.
  task automatic load_region(input shape_t shp, input logic [CFG_W-1:0] cx, cy,
                             input logic [CFG_W-1:0] c, s, ex, ey);
    logic [CFG_W-1:0] shape_word;
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
    shape_word    = CFG_W'($urandom);
    shape_word[0] = shp;
    write_reg(CFG_IDX_SPARE, CFG_W'($urandom));
    write_reg(CFG_SHAPE_KIND, shape_word);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_COS_ANGLE, c);
    write_reg(CFG_SIN_ANGLE, s);
    write_reg(CFG_EXTENT_X, ex);
    write_reg(CFG_EXTENT_Y, ey);
    quiet = ($urandom_range(0, 4) == 0);
  endtask

  // One point transfer; called and returning at a falling edge. Valid stays
  // high into the next call when that call draws no gap.
  task automatic send_point(input int px, input int py);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    point_x  = PT_W'(px);
    point_y  = PT_W'(py);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent_count = sent_count + 1;
  endtask

  // A coordinate within span pixels of a center, clipped to the frame.
  function automatic int near_coord(input int centre_px, input int span);
    int off;
    int v;
    off = $urandom_range(0, 2 * span);
    v   = centre_px + off - span;
    if (v < 0) v = 0;
    if (v > MAX_PX) v = MAX_PX;
    return v;
  endfunction

  // Stimulus.
  initial begin
    shape_t           shp;
    logic [CFG_W-1:0] cx;
    logic [CFG_W-1:0] cy;
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] s;
    logic [CFG_W-1:0] ex;
    logic [CFG_W-1:0] ey;
    real              theta;
    int               span;
    int               n_pts;
    int               mode;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    point_x   = '0;
    point_y   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Registers at their reset values: an ellipse with zero radii.
    send_point(0, 0);
    send_point(MAX_PX, MAX_PX);

    // Upright ellipse around (100,100) with radii 10 and 5 pixels; points on
    // and just past each boundary.
    load_region(SHAPE_ELLIPSE, 16'd1600, 16'd1600, 16'd16384, 16'd0, 16'd160, 16'd80);
    send_point(100, 100);
    send_point(110, 100);
    send_point(111, 100);
    send_point(100, 105);
    send_point(100, 106);
    send_point(90, 100);
    send_point(0, 0);
    send_point(MAX_PX, 0);

    // Rectangle turned by a quarter turn: width lies along the row axis.
    load_region(SHAPE_RECT, 16'd32000, 16'd16000, 16'd0, 16'd16384, 16'd640, 16'd160);
    send_point(2000, 1020);
    send_point(2000, 1021);
    send_point(2005, 1000);
    send_point(2006, 1000);

    // Rectangle with zero extents: only the center itself is inside.
    load_region(SHAPE_RECT, 16'hFFF0, 16'hFFF0, -16'sd16384, 16'd0, 16'd0, 16'd0);
    send_point(MAX_PX, MAX_PX);
    send_point(MAX_PX - 1, MAX_PX);
    send_point(0, 0);

    // Extreme register values with trig values out of range.
    load_region(SHAPE_ELLIPSE, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF);
    send_point(0, 0);
    send_point(MAX_PX, MAX_PX);
    send_point(0, MAX_PX);

    // Ellipse with only one radius zero, then the largest rectangle.
    load_region(SHAPE_ELLIPSE, 16'd800, 16'd800, 16'd16384, 16'd0, 16'd320, 16'd0);
    send_point(50, 50);
    load_region(SHAPE_RECT, 16'd0, 16'd0, -16'sd16384, -16'sd16384, 16'hFFFF, 16'hFFFF);
    send_point(MAX_PX, 0);

    // Random regions, most points clustered around the region.
    while (sent_count < RANDOM_POINTS + 23) begin
      shp  = shape_t'($urandom_range(0, 1));
      cx   = CFG_W'($urandom);
      cy   = CFG_W'($urandom);
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        c = CFG_W'($urandom);
        s = CFG_W'($urandom);
      end else begin
        theta = real'($urandom_range(0, 35999)) * 2.0 * PI_VAL / 36000.0;
        c     = CFG_W'($rtoi($cos(theta) * 16384.0));
        s     = CFG_W'($rtoi($sin(theta) * 16384.0));
        if (mode == 1) begin
          c = CFG_W'(16384);
          s = CFG_W'(0);
        end else if (mode == 2) begin
          c = CFG_W'(0);
          s = CFG_W'(-16384);
        end
      end
      case ($urandom_range(0, 15))
        0:       ex = '0;
        1:       ex = '1;
        default: ex = CFG_W'($urandom_range(16, 2048));
      endcase
      case ($urandom_range(0, 15))
        0:       ey = '0;
        1:       ey = '1;
        default: ey = CFG_W'($urandom_range(16, 2048));
      endcase
      load_region(shp, cx, cy, c, s, ex, ey);
      span = ((ex > ey) ? int'(ex) : int'(ey)) / 16 + 3;
      if (span > MAX_PX) span = MAX_PX;
      n_pts = $urandom_range(15, 45);
      repeat (n_pts) begin
        if ($urandom_range(0, 4) == 0)
          send_point($urandom_range(0, MAX_PX), $urandom_range(0, MAX_PX));
        else
          send_point(near_coord(int'(cx) / 16, span), near_coord(int'(cy) / 16, span));
      end
    end

    // Let every result arrive, then watch for stray results a while longer.
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
